FILE: rtl/core/hav_pkg.sv
// ----------------------------------------------------------------------------
// hav_pkg - shared types and constants for the haversine distance block
// Holds the CORDIC arctangent table and the sequencer state codes.
// ----------------------------------------------------------------------------
package hav_pkg;

	localparam int ITER = 30;
	localparam logic signed [39:0] CORDIC_GAIN = 40'sd652032874;
	localparam logic signed [39:0] Q_ONE = 40'sd1073741824;
	localparam logic signed [33:0] QUARTER_TURN = 34'sd180000000;
	localparam logic signed [33:0] HALF_TURN = 34'sd360000000;
	localparam logic signed [33:0] FULL_TURN = 34'sd720000000;
	localparam logic [33:0] PI_Q32 = 34'd13493037705;
	localparam logic [63:0] RAD_DIVISOR = 64'd1440000000;
	localparam logic [24:0] DIST_MAX = 25'h1FFFFFE;
	localparam logic [24:0] DIST_ALL_ONES = 25'h1FFFFFF;

	typedef enum logic [3:0] {
		ST_IDLE, ST_REDUCE, ST_CONV, ST_DIV, ST_SIN, ST_MUL, ST_SQRT, ST_ATAN, ST_SCALE,
		ST_OUT
	} hav_state_t;

	function automatic logic signed [39:0] arctan_q30(input logic [4:0] i);
		case (i)
			5'd0: arctan_q30 = 40'sd843314857;
			5'd1: arctan_q30 = 40'sd497837829;
			5'd2: arctan_q30 = 40'sd263043837;
			5'd3: arctan_q30 = 40'sd133525159;
			5'd4: arctan_q30 = 40'sd67021687;
			5'd5: arctan_q30 = 40'sd33543516;
			5'd6: arctan_q30 = 40'sd16775851;
			5'd7: arctan_q30 = 40'sd8388437;
			5'd8: arctan_q30 = 40'sd4194283;
			5'd9: arctan_q30 = 40'sd2097149;
			default: arctan_q30 = 40'sd1 <<< (5'd30 - i);
		endcase
	endfunction

endpackage

FILE: rtl/core/haversine_nearest_point.sv
// ----------------------------------------------------------------------------
// haversine_nearest_point - great-circle distance with nearest-point search
// One request at a time through a shared CORDIC, serial multiplier and
// serial square-root unit.
// ----------------------------------------------------------------------------
// Each request runs from acceptance to a valid result through four angle
// evaluations (a reduce step, a 34-step bit-serial multiply by pi, a 31-step
// restoring divide and 30 CORDIC steps, with load steps), four bit-serial
// multiplies, two digit-by-digit roots, a 30-step vectoring CORDIC, a scale
// multiply at two bits a cycle and an output state. The serial units work one
// bit or digit per cycle. A new request is taken while the previous result
// still waits in the output registers; the sequencer holds in its output
// state until that result is taken.
module haversine_nearest_point
	import hav_pkg::*;
#(
	parameter int MAX_POINTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [28:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [27:0] point_latitude,
	input  logic signed [28:0] point_longitude,
	input  logic               first_of_set,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [24:0]        distance_m,
	output logic [7:0]         point_index,
	output logic [7:0]         nearest_index,
	output logic [24:0]        nearest_distance_m
);

	localparam logic [7:0] LIMIT = (MAX_POINTS - 1 > 255) ? 8'd255 : 8'(MAX_POINTS - 1);
	localparam logic [1:0] REG_LAT = 2'd0, REG_LON = 2'd1, REG_RAD = 2'd2;

	logic signed [27:0] ref_lat_q;
	logic signed [28:0] ref_lon_q;
	logic [12:0] radius_q;
	logic [24:0] best_dist_q;
	logic [7:0]  best_idx_q, count_q;

	logic signed [27:0] lat_q;
	logic signed [28:0] lon_q;
	logic first_q;

	hav_state_t state_q, state_d;
	logic [1:0]  sel_q;          // which angle / product / root
	logic [5:0]  step_q;
	logic signed [33:0] ang_q;   // reduced angle, half microdegrees
	logic signed [39:0] x_q, y_q, z_q;
	logic signed [39:0] s1_q, s2_q, c1_q, c2_q, p_q, h_q, sq_y_q;
	// serial multiplier
	logic [63:0] macc_q;
	logic [33:0] mb_q;
	logic [63:0] ma_q;
	logic        mneg_q;
	// serial root, also remainder, divisor and quotient of the angle divide
	logic [63:0] rv_q, rres_q, rbit_q;
	logic [24:0] dist_q;

	logic out_valid_q;
	logic out_load;

	// reduce / multiply helpers
	logic signed [33:0] ang_sel, r0, r1, r2;
	logic signed [39:0] sh_x, sh_y, nz;
	logic [63:0] mul_a_sel;
	logic [33:0] mul_b_sel;
	logic        mul_neg_sel;
	logic signed [39:0] op_a, op_b;
	logic signed [63:0] mres;
	logic [63:0] rsum;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		case (sel_q)
			2'd0: ang_sel = 34'(lat_q) - 34'(ref_lat_q);
			2'd1: ang_sel = 34'(lon_q) - 34'(ref_lon_q);
			2'd2: ang_sel = (34'(ref_lat_q) <<< 1) + QUARTER_TURN;
			default: ang_sel = (34'(lat_q) <<< 1) + QUARTER_TURN;
		endcase
	end

	// fold a value already within two turns into [-90, 90] degrees
	always_comb begin
		r0 = ang_q;
		if (r0 >= FULL_TURN) r0 = r0 - FULL_TURN;
		if (r0 <= -FULL_TURN) r0 = r0 + FULL_TURN;
		r1 = r0;
		if (r1 >= HALF_TURN) r1 = r1 - FULL_TURN;
		if (r1 < -HALF_TURN) r1 = r1 + FULL_TURN;
		r2 = r1;
		if (r2 > QUARTER_TURN) r2 = HALF_TURN - r2;
		if (r2 < -QUARTER_TURN) r2 = -HALF_TURN - r2;
	end

	assign sh_x = x_q >>> step_q[4:0];
	assign sh_y = y_q >>> step_q[4:0];
	assign nz = arctan_q30(step_q[4:0]);

	// operand pairs for the multiplies: s1*s1, s2*s2, c1*c2, then the two products
	always_comb begin
		case (sel_q)
			2'd0: begin op_a = s1_q; op_b = s1_q; end
			2'd1: begin op_a = s2_q; op_b = s2_q; end
			2'd2: begin op_a = c1_q; op_b = c2_q; end
			default: begin op_a = p_q; op_b = sq_y_q; end
		endcase
		mul_neg_sel = (op_a < 0) != (op_b < 0);
		mul_a_sel = 64'(op_a < 0 ? -op_a : op_a);
		mul_b_sel = 34'(op_b < 0 ? -op_b : op_b);
	end

	assign mres = mneg_q ? -$signed(64'((macc_q + 64'd536870912) >> 30))
		: $signed(64'((macc_q + 64'd536870912) >> 30));
	assign rsum = rres_q + rbit_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid && in_ready) state_d = ST_REDUCE;
			ST_REDUCE: state_d = ST_CONV;
			ST_CONV:   if (step_q == 6'd34) state_d = ST_DIV;
			ST_DIV:    if (step_q == 6'd32) state_d = ST_SIN;
			ST_SIN: begin
				if (step_q == 6'd29) state_d = (sel_q == 2'd3) ? ST_MUL : ST_REDUCE;
			end
			ST_MUL: begin
				if (step_q == 6'd34 && sel_q == 2'd3) state_d = ST_SQRT;
			end
			ST_SQRT:   if (step_q == 6'd33 && sel_q == 2'd1) state_d = ST_ATAN;
			ST_ATAN:   if (step_q == 6'd29) state_d = ST_SCALE;
			ST_SCALE:  if (step_q == 6'd14) state_d = ST_OUT;
			ST_OUT:    if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// register file, set tracking and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lat_q <= '0;
			ref_lon_q <= '0;
			radius_q <= 13'd6371;
			best_dist_q <= DIST_ALL_ONES;
			best_idx_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
			distance_m <= '0;
			point_index <= '0;
			nearest_index <= '0;
			nearest_distance_m <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LAT: ref_lat_q <= cfg_data[27:0];
					REG_LON: ref_lon_q <= cfg_data;
					REG_RAD: radius_q <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				distance_m <= dist_q;
				if (first_q) begin
					point_index <= 8'd0;
					best_dist_q <= dist_q;
					best_idx_q <= 8'd0;
					nearest_index <= 8'd0;
					nearest_distance_m <= dist_q;
					count_q <= (8'd0 < LIMIT) ? 8'd1 : LIMIT;
				end else begin
					point_index <= count_q;
					if (dist_q < best_dist_q) begin
						best_dist_q <= dist_q;
						best_idx_q <= count_q;
						nearest_index <= count_q;
						nearest_distance_m <= dist_q;
					end else begin
						nearest_index <= best_idx_q;
						nearest_distance_m <= best_dist_q;
					end
					count_q <= (count_q < LIMIT) ? count_q + 8'd1 : LIMIT;
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					lat_q <= point_latitude;
					lon_q <= point_longitude;
					first_q <= first_of_set;
					sel_q <= 2'd0;
				end
			end
			ST_REDUCE: begin
				ang_q <= ang_sel;
				step_q <= '0;
				macc_q <= '0;
			end
			ST_CONV: begin
				// |r| * pi_q32, one multiplier bit per cycle
				if (step_q == 6'd0) begin
					ang_q <= r2;
					mb_q <= PI_Q32;
					ma_q <= 64'(r2 < 0 ? -r2 : r2);
					mneg_q <= r2 < 0;
					macc_q <= '0;
				end else begin
					if (mb_q[0]) macc_q <= macc_q + ma_q;
					mb_q <= mb_q >> 1;
					ma_q <= ma_q << 1;
				end
				step_q <= (step_q == 6'd34) ? 6'd0 : step_q + 6'd1;
			end
			ST_DIV: begin
				// restoring divide to radians, one quotient bit a cycle
				if (step_q == 6'd0) begin
					rv_q <= macc_q + (RAD_DIVISOR >> 1);
					rbit_q <= RAD_DIVISOR << 30;
					rres_q <= '0;
					step_q <= 6'd1;
				end else if (step_q < 6'd32) begin
					if (rv_q >= rbit_q) begin
						rv_q <= rv_q - rbit_q;
						rres_q <= {rres_q[62:0], 1'b1};
					end else begin
						rres_q <= {rres_q[62:0], 1'b0};
					end
					rbit_q <= rbit_q >> 1;
					step_q <= step_q + 6'd1;
				end else begin
					z_q <= mneg_q ? -$signed(40'(rres_q)) : $signed(40'(rres_q));
					x_q <= CORDIC_GAIN;
					y_q <= '0;
					step_q <= '0;
				end
			end
			ST_SIN: begin
				if (z_q >= 0) begin
					x_q <= x_q - sh_y; y_q <= y_q + sh_x; z_q <= z_q - nz;
				end else begin
					x_q <= x_q + sh_y; y_q <= y_q - sh_x; z_q <= z_q + nz;
				end
				if (step_q == 6'd29) begin
					step_q <= '0;
					sel_q <= sel_q + 2'd1;
					case (sel_q)
						2'd0: s1_q <= (z_q >= 0) ? y_q + sh_x : y_q - sh_x;
						2'd1: s2_q <= (z_q >= 0) ? y_q + sh_x : y_q - sh_x;
						2'd2: c1_q <= (z_q >= 0) ? y_q + sh_x : y_q - sh_x;
						default: begin
							c2_q <= (z_q >= 0) ? y_q + sh_x : y_q - sh_x;
							p_q <= '0;
						end
					endcase
				end else begin
					step_q <= step_q + 6'd1;
				end
			end
			ST_MUL: begin
				if (step_q == 6'd0) begin
					ma_q <= mul_a_sel; mb_q <= mul_b_sel; mneg_q <= mul_neg_sel;
					macc_q <= '0;
					step_q <= 6'd1;
				end else if (step_q < 6'd34) begin
					if (mb_q[0]) macc_q <= macc_q + ma_q;
					mb_q <= mb_q >> 1;
					ma_q <= ma_q << 1;
					step_q <= step_q + 6'd1;
				end else begin
					step_q <= '0;
					case (sel_q)
						2'd0: begin h_q <= 40'(mres); sel_q <= 2'd1; end
						2'd1: begin sq_y_q <= 40'(mres); sel_q <= 2'd2; end
						2'd2: begin p_q <= 40'(mres); sel_q <= 2'd3; end
						default: begin
							// final term, clamp h into [0, 1]
							if (h_q + 40'(mres) < 0) h_q <= '0;
							else if (h_q + 40'(mres) > Q_ONE) h_q <= Q_ONE;
							else h_q <= h_q + 40'(mres);
							sel_q <= 2'd0;
						end
					endcase
				end
			end
			ST_SQRT: begin
				// digit-by-digit root, one result bit a cycle
				if (step_q == 6'd0) begin
					rv_q <= (sel_q == 2'd0) ? 64'(h_q) << 30 : 64'(Q_ONE - h_q) << 30;
					rres_q <= '0;
					rbit_q <= 64'd1 << 62;
					step_q <= 6'd1;
				end else if (step_q < 6'd33) begin
					if (rv_q >= rsum) begin
						rv_q <= rv_q - rsum;
						rres_q <= (rres_q >> 1) + rbit_q;
					end else begin
						rres_q <= rres_q >> 1;
					end
					rbit_q <= rbit_q >> 2;
					step_q <= step_q + 6'd1;
				end else begin
					step_q <= '0;
					if (sel_q == 2'd0) begin
						y_q <= 40'(rres_q);
						sel_q <= 2'd1;
					end else begin
						x_q <= 40'(rres_q);
						z_q <= '0;
						sel_q <= 2'd0;
					end
				end
			end
			ST_ATAN: begin
				if (y_q >= 0) begin
					x_q <= x_q + sh_y; y_q <= y_q - sh_x; z_q <= z_q + nz;
				end else begin
					x_q <= x_q - sh_y; y_q <= y_q + sh_x; z_q <= z_q - nz;
				end
				if (step_q == 6'd29) begin
					step_q <= '0;
					macc_q <= '0;
					ma_q <= 64'(((y_q >= 0) ? z_q + nz : z_q - nz) < 0 ? 40'sd0
						: ((y_q >= 0) ? z_q + nz : z_q - nz)) << 1;
					mb_q <= 34'(radius_q) * 34'd1000;
				end else begin
					step_q <= step_q + 6'd1;
				end
			end
			ST_SCALE: begin
				// two multiplier bits a cycle over the scale factor (radius times 1000, at most 23 bits)
				macc_q <= macc_q + (mb_q[0] ? ma_q : 64'd0) + (mb_q[1] ? ma_q << 1 : 64'd0);
				mb_q <= mb_q >> 2;
				ma_q <= ma_q << 2;
				if (step_q == 6'd14) begin
					step_q <= '0;
					if (((macc_q + 64'd536870912) >> 30) > 64'(DIST_MAX)) dist_q <= DIST_MAX;
					else dist_q <= 25'((macc_q + 64'd536870912) >> 30);
				end else begin
					step_q <= step_q + 6'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: test/haversine_nearest_point_tb.sv
// ----------------------------------------------------------------------------
// haversine_nearest_point_tb - self-checking bench for the haversine block
// Feeds candidate points under several reference points and radii, predicts
// each distance and the running nearest point of the set, and checks every
// result field in order, with random idle cycles on both handshakes.
// ----------------------------------------------------------------------------
module haversine_nearest_point_tb
	import hav_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_POINTS = 256;
	localparam int INDEX_LIMIT = (MAX_POINTS - 1 > 255) ? 255 : MAX_POINTS - 1;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [1:0] REG_REF_LAT = 2'd0;
	localparam logic [1:0] REG_REF_LON = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;
	localparam longint unsigned RAD_SCALE = 64'd13493037705;
	localparam longint unsigned RAD_DIV = 64'd1440000000;

	typedef struct {
		logic signed [27:0] lat;
		logic signed [28:0] lon;
		logic               first;
	} point_t;

	typedef struct {
		logic [24:0] meters;
		logic [7:0]  idx;
		logic [7:0]  near_idx;
		logic [24:0] near_dist;
	} fix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [28:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [27:0] point_latitude = '0;
	logic signed [28:0] point_longitude = '0;
	logic first_of_set = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [24:0] distance_m;
	logic [7:0] point_index;
	logic [7:0] nearest_index;
	logic [24:0] nearest_distance_m;

	point_t point_queue[$];
	fix_t due_fixes[$];

	// predictor copy of registers and search state
	longint ref_lat = 0;
	longint ref_lon = 0;
	longint radius_km = 6371;
	logic [24:0] best_dist = DIST_ALL_ONES;
	int best_idx = 0;
	int next_idx = 0;

	longint atan_tab[30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2
	};

	int errors = 0;
	int checked = 0;
	int settings = 1;
	int gap_left = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	haversine_nearest_point #(.MAX_POINTS(MAX_POINTS)) DUT (.*);

	always #2 clk = ~clk;

	// angle in half-microdegree units to sine in Q2.30
	function automatic longint sine_q30(longint a);
		longint r, z, x, y, nx, ny;
		longint unsigned m;
		bit neg;
		r = a % 720000000;
		if (r >= 360000000) r -= 720000000;
		if (r < -360000000) r += 720000000;
		if (r > 180000000) r = 360000000 - r;
		if (r < -180000000) r = -360000000 - r;
		neg = r < 0;
		m = neg ? -r : r;
		z = (m * RAD_SCALE + RAD_DIV / 2) / RAD_DIV;
		if (neg) z = -z;
		x = 652032874;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
			end else begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
			end
			x = nx; y = ny;
		end
		return y;
	endfunction

	function automatic longint mul_q30(longint a, longint b);
		longint unsigned ua, ub;
		longint p;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		p = (ua * ub + (64'd1 << 29)) >> 30;
		return ((a < 0) != (b < 0)) ? -p : p;
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint arctan2_q30(longint y, longint x);
		longint z, nx, ny;
		z = 0;
		for (int i = 0; i < 30; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
			end
			x = nx; y = ny;
		end
		return z;
	endfunction

	function automatic logic [24:0] great_circle_m(longint lat, longint lon);
		longint s1, s2, c1, c2, h, theta;
		longint unsigned d;
		s1 = sine_q30(lat - ref_lat);
		s2 = sine_q30(lon - ref_lon);
		c1 = sine_q30(2 * ref_lat + 180000000);
		c2 = sine_q30(2 * lat + 180000000);
		h = mul_q30(s1, s1) + mul_q30(mul_q30(c1, c2), mul_q30(s2, s2));
		if (h < 0) h = 0;
		if (h > (64'sd1 << 30)) h = 64'sd1 << 30;
		theta = 2 * arctan2_q30(root_floor(h << 30), root_floor(((64'sd1 << 30) - h) << 30));
		if (theta < 0) theta = 0;
		d = (longint'(theta) * (radius_km * 1000) + (64'd1 << 29)) >> 30;
		if (d > DIST_MAX) d = DIST_MAX;
		return d[24:0];
	endfunction

	task automatic predict_point(input point_t p);
		fix_t f;
		if (p.first) begin
			next_idx = 0;
			best_dist = DIST_ALL_ONES;
			best_idx = 0;
		end
		f.meters = great_circle_m(p.lat, p.lon);
		f.idx = 8'(next_idx);
		if (f.meters < best_dist) begin
			best_dist = f.meters;
			best_idx = next_idx;
		end
		f.near_idx = 8'(best_idx);
		f.near_dist = best_dist;
		due_fixes.push_back(f);
		next_idx = next_idx < INDEX_LIMIT ? next_idx + 1 : INDEX_LIMIT;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver: hold the request until taken, then load the next one
	always @(posedge clk or negedge arst_n) begin
		point_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				p.lat = point_latitude;
				p.lon = point_longitude;
				p.first = first_of_set;
				predict_point(p);
			end
			if (!(in_valid && !in_ready)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (point_queue.size() > 0) begin
					p = point_queue.pop_front();
					point_latitude <= p.lat;
					point_longitude <= p.lon;
					first_of_set <= p.first;
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 3) == 0)
						gap_left <= $urandom_range(1, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check results in order, stall in bursts
	always @(posedge clk or negedge arst_n) begin
		fix_t f;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_fixes.size() == 0) begin
					report_mismatch("unexpected result, distance", distance_m, -1);
				end else begin
					f = due_fixes.pop_front();
					checked++;
					if (distance_m !== f.meters) report_mismatch("distance_m", distance_m, f.meters);
					if (point_index !== f.idx) report_mismatch("point_index", point_index, f.idx);
					if (nearest_index !== f.near_idx)
						report_mismatch("nearest_index", nearest_index, f.near_idx);
					if (nearest_distance_m !== f.near_dist)
						report_mismatch("nearest_distance_m", nearest_distance_m, f.near_dist);
				end
			end
			if (quiet) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left <= $urandom_range(1, 5);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d cycles without a handshake", idle_cycles);
				$display("haversine_nearest_point_tb: errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic add_point(input longint lat, input longint lon, input logic first);
		point_t p;
		p.lat = 28'(lat);
		p.lon = 29'(lon);
		p.first = first;
		point_queue.push_back(p);
	endtask

	// mostly in-range points, some full-width; sets restart now and then
	task automatic add_random(input int n, input int set_odds);
		logic signed [27:0] lat;
		logic signed [28:0] lon;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				lat = 28'($urandom);
				lon = 29'($urandom);
			end else begin
				lat = 28'(longint'($urandom_range(0, 180000000)) - 90000000);
				lon = 29'(longint'($urandom_range(0, 360000000)) - 180000000);
			end
			add_point(lat, lon, set_odds > 0 && $urandom_range(0, set_odds) == 0);
		end
	endtask

	task automatic drain();
		while (point_queue.size() > 0 || in_valid || due_fixes.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input longint value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[28:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_REF_LAT: ref_lat = logic'(value[27]) ? value[27:0] - (64'sd1 << 28) : value[27:0];
			REG_REF_LON: ref_lon = logic'(value[28]) ? value[28:0] - (64'sd1 << 29) : value[28:0];
			default: radius_km = longint'(value[12:0]);
		endcase
	endtask

	task automatic set_reference(input longint lat, input longint lon, input longint km);
		write_reg(REG_REF_LAT, lat);
		write_reg(REG_REF_LON, lon);
		write_reg(REG_RADIUS, km);
		settings++;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// no set flag after reset, poles, date line, ties, out-of-range angles
		add_point(0, 0, 1'b0);
		add_point(90000000, 0, 1'b0);
		add_point(-90000000, 0, 1'b0);
		add_point(0, 180000000, 1'b0);
		add_point(0, -180000000, 1'b0);
		add_point(0, 0, 1'b0);
		add_point(-(64'sd1 << 27), -(64'sd1 << 28), 1'b0);
		add_point((64'sd1 << 27) - 1, (64'sd1 << 28) - 1, 1'b0);
		add_point(0, 1, 1'b0);
		add_point(1, 0, 1'b0);
		add_point(45000000, 45000000, 1'b1);
		add_point(-45000000, -135000000, 1'b0);
		add_point(45000000, 45000000, 1'b0);
		add_point(100000000, 10000000, 1'b0);
		add_point(0, 270000000, 1'b0);
		add_point(-1, -1, 1'b1);
		add_point(89999999, 179999999, 1'b0);
		add_point(-90000000, 180000000, 1'b0);
		drain();

		set_reference(90000000, -180000000, 8000);
		add_random(200, 8);
		drain();

		// one long set to run the index into saturation
		set_reference(-90000000, 180000000, 1);
		add_random(1, 0);
		point_queue[0].first = 1'b1;
		add_random(299, 0);
		drain();

		set_reference(-(64'sd1 << 27), (64'sd1 << 28) - 1, 0);
		add_random(50, 6);
		drain();

		set_reference(37774900, -122419400, 8191);
		add_random(250, 10);
		drain();

		set_reference(-33868800, 151209300, 6371);
		add_random(200, 10);
		drain();

		quiet = 1'b1;
		add_random(130, 10);
		drain();

		repeat (20) @(posedge clk);
		$display("%0d results checked under %0d reference settings,", checked, settings);
		$display("covering poles, wraparound, ties, set restarts and index saturation");
		if (errors == 0) begin
			$display("haversine_nearest_point_tb: clean");
		end else begin
			$display("haversine_nearest_point_tb: errors");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/hav_pkg.sv
rtl/core/haversine_nearest_point.sv
test/haversine_nearest_point_tb.sv
